// ===== rtl/mfdo_pkg.sv =====
// Shared constants and types for the drop-oldest message queue.
`timescale 1ns / 1ps

package mfdo_pkg;

  localparam int DEF_QUEUE_DEPTH   = 8;
  localparam int DEF_MESSAGE_BYTES = 64;

  localparam logic [3:0] MAX_ENTRIES_RESET = 4'd8;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_PUSH   = 3'd0;
  localparam opcode_t OP_POP    = 3'd1;
  localparam opcode_t OP_CLEAR  = 3'd2;
  localparam opcode_t OP_READ   = 3'd3;
  localparam opcode_t OP_LENGTH = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_TRUNC = 2'd2;
  localparam status_t ST_DROP  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DONE
  } fsm_state_t;

endpackage

// ===== rtl/mfdo_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mfdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/message_fifo_drop_oldest.sv =====
// Top level of the drop-oldest byte message queue.
//
// Each word on the input stream passes through S_IDLE, S_LEN and S_DONE: in
// the cycle it is accepted the queue pointers are updated and the byte memory
// is written (push) or read (read byte); in S_LEN the length memory is read
// at the new front slot; in S_DONE the result register is loaded. A result
// that is not taken holds S_DONE, and the input stays not ready until the new
// result is loaded. Message bytes live in a QUEUE_DEPTH x MESSAGE_BYTES memory
// and lengths in a QUEUE_DEPTH memory, both with registered read data.
// Neither memory is cleared; only values from committed slots reach the result.
// The effective limit from max_entries is clamped to 1..QUEUE_DEPTH; the user
// must write max_entries only while idle, as the block does not enforce this.
`timescale 1ns / 1ps

module message_fifo_drop_oldest
  import mfdo_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int MESSAGE_BYTES = DEF_MESSAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_entries
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] byte_index, [15:14] zero
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  input  logic        s_tlast,   // last_byte
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] read_data, [14:8] front_length,
                                 // [18:15] entry_count, [23:19] zero
  output logic [2:0]  m_tuser    // [0] queue_empty, [2:1] status
);

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OFF_W  = $clog2(MESSAGE_BYTES + 1);
  localparam int BYTE_DEPTH = QUEUE_DEPTH * MESSAGE_BYTES;
  localparam int ADDR_W = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

  // input fields
  opcode_t    s_op;
  logic [7:0] s_byte;
  logic [5:0] s_idx;
  assign s_op   = s_tuser;
  assign s_byte = s_tdata[7:0];
  assign s_idx  = s_tdata[13:8];

  // queue state
  logic [3:0]        max_entries;
  logic [SLOT_W-1:0] head_slot, head_slot_next;
  logic [SLOT_W-1:0] tail_slot, tail_slot_next;
  logic [CNT_W-1:0]  count_held, count_held_next;
  logic [OFF_W-1:0]  write_offset, write_offset_next;

  // item held between steps
  opcode_t    op_q;
  logic [5:0] idx_q;
  status_t    status_q, status_next;

  fsm_state_t state, state_next;
  logic       accept;
  logic       len_rd_en;
  logic       load_out;

  logic [CNT_W-1:0] limit;
  logic             dropped, trunc;

  logic              byte_we, byte_re;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;
  logic [7:0]        byte_rdata;
  logic              len_we;
  logic [OFF_W-1:0]  len_wdata, len_rdata;

  logic [7:0]       rd_value;
  logic [OFF_W-1:0] flen;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0]  n);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(s) + (CNT_W+1)'(n);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return SLOT_W'(sum);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_entries <= cfg_data;
    end
  end

  always_comb begin
    if (max_entries == 4'd0) begin
      limit = CNT_W'(1);
    end else if (32'(max_entries) > 32'(QUEUE_DEPTH)) begin
      limit = CNT_W'(QUEUE_DEPTH);
    end else begin
      limit = CNT_W'(max_entries);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    len_rd_en  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        len_rd_en  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // pointer update for the accepted word
  always_comb begin
    head_slot_next    = head_slot;
    tail_slot_next    = tail_slot;
    count_held_next   = count_held;
    write_offset_next = write_offset;
    dropped     = 1'b0;
    trunc       = 1'b0;
    status_next = ST_OK;
    byte_we     = 1'b0;
    byte_re     = 1'b0;
    len_we      = 1'b0;
    len_wdata   = write_offset;
    byte_waddr  = ADDR_W'(tail_slot) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(write_offset);
    if (32'(s_idx) < 32'(MESSAGE_BYTES)) begin
      byte_raddr = ADDR_W'(head_slot) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(s_idx);
    end else begin
      byte_raddr = ADDR_W'(head_slot) * ADDR_W'(MESSAGE_BYTES);
    end
    case (s_op)
      OP_PUSH: begin
        // drop oldest messages on the first byte of a message
        if (write_offset == '0 && count_held_next >= limit) begin
          head_slot_next  = slot_add(head_slot_next,
                                     count_held_next - (limit - CNT_W'(1)));
          count_held_next = limit - CNT_W'(1);
          dropped = 1'b1;
        end
        if (32'(write_offset) < 32'(MESSAGE_BYTES)) begin
          byte_we = accept;
          write_offset_next = write_offset + OFF_W'(1);
        end else begin
          trunc = 1'b1;
        end
        if (s_tlast) begin
          // drop again at commit, then close the message
          if (count_held_next >= limit) begin
            head_slot_next  = slot_add(head_slot_next,
                                       count_held_next - (limit - CNT_W'(1)));
            count_held_next = limit - CNT_W'(1);
            dropped = 1'b1;
          end
          len_we            = accept;
          len_wdata         = write_offset_next;
          tail_slot_next    = slot_add(tail_slot, CNT_W'(1));
          count_held_next   = count_held_next + CNT_W'(1);
          write_offset_next = '0;
        end
        if (dropped) begin
          status_next = ST_DROP;
        end else if (trunc) begin
          status_next = ST_TRUNC;
        end
      end
      OP_POP: begin
        if (count_held == '0) begin
          status_next = ST_EMPTY;
        end else begin
          head_slot_next  = slot_add(head_slot, CNT_W'(1));
          count_held_next = count_held - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        head_slot_next    = '0;
        tail_slot_next    = '0;
        count_held_next   = '0;
        write_offset_next = '0;
      end
      OP_READ: begin
        if (count_held == '0) begin
          status_next = ST_EMPTY;
        end else begin
          byte_re = accept;
        end
      end
      OP_LENGTH: begin
        if (count_held == '0) begin
          status_next = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot    <= '0;
      tail_slot    <= '0;
      count_held   <= '0;
      write_offset <= '0;
    end else if (accept) begin
      head_slot    <= head_slot_next;
      tail_slot    <= tail_slot_next;
      count_held   <= count_held_next;
      write_offset <= write_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= s_op;
      idx_q    <= s_idx;
      status_q <= status_next;
    end
  end

  mfdo_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_we),
    .wr_addr (byte_waddr),
    .wr_data (s_byte),
    .rd_en   (byte_re),
    .rd_addr (byte_raddr),
    .rd_data (byte_rdata)
  );

  mfdo_ram #(
    .WIDTH (OFF_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (tail_slot),
    .wr_data (len_wdata),
    .rd_en   (len_rd_en),
    .rd_addr (head_slot),
    .rd_data (len_rdata)
  );

  // result assembly: bytes past the front length read as zero
  always_comb begin
    rd_value = 8'd0;
    if (op_q == OP_READ && status_q == ST_OK &&
        32'(idx_q) < 32'(len_rdata) && 32'(idx_q) < 32'(MESSAGE_BYTES)) begin
      rd_value = byte_rdata;
    end
    flen = (count_held == '0) ? '0 : len_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'd0, 4'(count_held), 7'(flen), rd_value};
      m_tuser <= {status_q, count_held == '0};
    end
  end

endmodule
